// ===== src/traffic_light_controller_macros.svh =====
// Assertion macros for the traffic light controller.
// Used by traffic_light_controller.sv; no other dependencies.
`ifndef TRAFFIC_LIGHT_CONTROLLER_MACROS_SVH
`define TRAFFIC_LIGHT_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define TLC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define TLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/tlc_pkg.sv =====
// Shared constants for the traffic light controller: field widths,
// register indexes and register reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlc_pkg;

   // Field widths
   localparam int unsigned PHASE_W    = 3;
   localparam int unsigned TIME_W     = 16;
   localparam int unsigned DEBOUNCE_W = 8;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_TIME        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_BLINK_TIME  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_YELLOW_TIME       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_TIME          = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_YELLOW_TIME   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_HALF_PERIOD = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_TIME     = 3'd6;

   // Register reset values, in milliseconds
   localparam logic [TIME_W-1:0]     GREEN_TIME_RST        = 16'd15000;
   localparam logic [TIME_W-1:0]     GREEN_BLINK_TIME_RST  = 16'd3000;
   localparam logic [TIME_W-1:0]     YELLOW_TIME_RST       = 16'd3000;
   localparam logic [TIME_W-1:0]     RED_TIME_RST          = 16'd15000;
   localparam logic [TIME_W-1:0]     RED_YELLOW_TIME_RST   = 16'd2000;
   localparam logic [TIME_W-1:0]     BLINK_HALF_PERIOD_RST = 16'd500;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_TIME_RST     = 8'd50;

endpackage

`default_nettype wire

// ===== src/tlc_if.sv =====
// Valid/ready channel interfaces for the traffic light controller:
// tick/button requests in, lamp responses out. Depends on tlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tlc_req_if;
   logic valid;
   logic ready;
   logic tick;
   logic button_level;

   modport source (output valid, output tick, output button_level, input ready);
   modport sink   (input valid, input tick, input button_level, output ready);
endinterface

interface tlc_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      red_lamp;
   logic                      yellow_lamp;
   logic                      green_lamp;
   logic [tlc_pkg::PHASE_W-1:0] phase;

   modport source (output valid, output red_lamp, output yellow_lamp,
                   output green_lamp, output phase, input ready);
   modport sink   (input valid, input red_lamp, input yellow_lamp,
                   input green_lamp, input phase, output ready);
endinterface

`default_nettype wire

// ===== src/traffic_light_controller.sv =====
// Traffic light controller: a request beat goes through the input register,
// then the result register; throughput 1 beat per cycle while the response
// channel does not stall; the debounce/phase update between them is combinational.
// Synchronous active-high reset: phase green, counters zero, button released,
// registers back to their default times, both channel stages empty.
`timescale 1ns / 1ps
`default_nettype none

`include "traffic_light_controller_macros.svh"

module traffic_light_controller (
   input  wire                            clock,
   input  wire                            reset,
   tlc_req_if.sink                        req_ch,
   tlc_rsp_if.source                      rsp_ch,
   input  wire                            csr_we,
   input  wire [tlc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [tlc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic [tlc_pkg::PHASE_W-1:0] {
      PH_GREEN        = 3'd0,
      PH_GREEN_BLINK  = 3'd1,
      PH_YELLOW       = 3'd2,
      PH_RED          = 3'd3,
      PH_RED_YELLOW   = 3'd4,
      PH_YELLOW_BLINK = 3'd5
   } phase_type;

   localparam logic [tlc_pkg::TIME_W-1:0]     TIME_MAX     = '1;
   localparam logic [tlc_pkg::DEBOUNCE_W-1:0] DEBOUNCE_MAX = '1;

   // Configuration registers
   logic [tlc_pkg::TIME_W-1:0]     green_time_ff, green_blink_time_ff, yellow_time_ff;
   logic [tlc_pkg::TIME_W-1:0]     red_time_ff, red_yellow_time_ff, blink_half_ff;
   logic [tlc_pkg::DEBOUNCE_W-1:0] debounce_time_ff;

   // Input stage
   logic in_valid_ff;
   logic in_tick_ff, in_level_ff;

   // Sequencer state
   phase_type                      phase_ff, phase_in;
   logic [tlc_pkg::TIME_W-1:0]     phase_elapsed_ff, phase_elapsed_in;
   logic [tlc_pkg::TIME_W-1:0]     blink_elapsed_ff, blink_elapsed_in;
   logic                           blink_on_ff, blink_on_in;
   logic [tlc_pkg::DEBOUNCE_W-1:0] debounce_count_ff, debounce_count_in;
   logic                           previous_raw_ff, previous_raw_in;
   logic                           stable_button_ff, stable_button_in;

   // Result stage
   logic                           rsp_valid_ff;
   logic                           red_ff, yellow_ff, green_ff;
   logic                           red_in, yellow_in, green_in;
   logic [tlc_pkg::PHASE_W-1:0]    rsp_phase_ff;

   logic advance;
   logic press;
   logic [tlc_pkg::TIME_W-1:0] phase_limit;

   // Stage handshake: input register moves into the result register
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.red_lamp    = red_ff;
   assign rsp_ch.yellow_lamp = yellow_ff;
   assign rsp_ch.green_lamp  = green_ff;
   assign rsp_ch.phase       = rsp_phase_ff;

   // Time limit of the current timed phase
   always_comb begin
      case (phase_ff)
         PH_GREEN:       phase_limit = green_time_ff;
         PH_GREEN_BLINK: phase_limit = green_blink_time_ff;
         PH_YELLOW:      phase_limit = yellow_time_ff;
         PH_RED:         phase_limit = red_time_ff;
         PH_RED_YELLOW:  phase_limit = red_yellow_time_ff;
         default:        phase_limit = TIME_MAX;
      endcase
   end

   // Debounce, press handling, blink and phase timing for one beat
   always_comb begin
      phase_in         = phase_ff;
      phase_elapsed_in = phase_elapsed_ff;
      blink_elapsed_in = blink_elapsed_ff;
      blink_on_in      = blink_on_ff;
      stable_button_in = stable_button_ff;
      previous_raw_in  = in_level_ff;
      press            = 1'b0;

      // debounce counter
      if (in_level_ff != previous_raw_ff) begin
         debounce_count_in = '0;
      end else if (in_tick_ff && debounce_count_ff != DEBOUNCE_MAX) begin
         debounce_count_in = debounce_count_ff + 1'b1;
      end else begin
         debounce_count_in = debounce_count_ff;
      end

      // accepted level; a low level is a press
      if (debounce_count_in >= debounce_time_ff && in_level_ff != stable_button_ff) begin
         stable_button_in = in_level_ff;
         if (!in_level_ff) begin
            press = 1'b1;
            if (phase_ff == PH_YELLOW_BLINK) begin
               phase_in         = PH_YELLOW;
               phase_elapsed_in = '0;
            end else begin
               phase_in         = PH_YELLOW_BLINK;
               blink_elapsed_in = '0;
               blink_on_in      = 1'b0;
            end
         end
      end

      if (in_tick_ff && !press) begin
         // blink toggle in the blinking phases
         if (phase_ff == PH_GREEN_BLINK || phase_ff == PH_YELLOW_BLINK) begin
            if (blink_elapsed_ff != TIME_MAX) begin
               blink_elapsed_in = blink_elapsed_ff + 1'b1;
            end
            if (blink_elapsed_in >= blink_half_ff) begin
               blink_elapsed_in = '0;
               blink_on_in      = !blink_on_ff;
            end
         end
         // phase timer, stopped in service mode
         if (phase_ff != PH_YELLOW_BLINK && phase_ff <= PH_RED_YELLOW) begin
            if (phase_elapsed_ff != TIME_MAX) begin
               phase_elapsed_in = phase_elapsed_ff + 1'b1;
            end
            if (phase_elapsed_in >= phase_limit) begin
               phase_elapsed_in = '0;
               case (phase_ff)
                  PH_GREEN: begin
                     phase_in         = PH_GREEN_BLINK;
                     blink_elapsed_in = '0;
                     blink_on_in      = 1'b0;
                  end
                  PH_GREEN_BLINK: phase_in = PH_YELLOW;
                  PH_YELLOW:      phase_in = PH_RED;
                  PH_RED:         phase_in = PH_RED_YELLOW;
                  default:        phase_in = PH_GREEN;
               endcase
            end
         end
      end
   end

   // Lamp decode from the updated state
   always_comb begin
      red_in    = 1'b0;
      yellow_in = 1'b0;
      green_in  = 1'b0;
      case (phase_in)
         PH_GREEN:       green_in = 1'b1;
         PH_GREEN_BLINK: green_in = blink_on_in;
         PH_YELLOW:      yellow_in = 1'b1;
         PH_RED:         red_in = 1'b1;
         PH_RED_YELLOW: begin
            red_in    = 1'b1;
            yellow_in = 1'b1;
         end
         default:        yellow_in = blink_on_in;
      endcase
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         green_time_ff       <= tlc_pkg::GREEN_TIME_RST;
         green_blink_time_ff <= tlc_pkg::GREEN_BLINK_TIME_RST;
         yellow_time_ff      <= tlc_pkg::YELLOW_TIME_RST;
         red_time_ff         <= tlc_pkg::RED_TIME_RST;
         red_yellow_time_ff  <= tlc_pkg::RED_YELLOW_TIME_RST;
         blink_half_ff       <= tlc_pkg::BLINK_HALF_PERIOD_RST;
         debounce_time_ff    <= tlc_pkg::DEBOUNCE_TIME_RST;
      end else if (csr_we) begin
         case (csr_index)
            tlc_pkg::CSR_GREEN_TIME:        green_time_ff       <= csr_wdata;
            tlc_pkg::CSR_GREEN_BLINK_TIME:  green_blink_time_ff <= csr_wdata;
            tlc_pkg::CSR_YELLOW_TIME:       yellow_time_ff      <= csr_wdata;
            tlc_pkg::CSR_RED_TIME:          red_time_ff         <= csr_wdata;
            tlc_pkg::CSR_RED_YELLOW_TIME:   red_yellow_time_ff  <= csr_wdata;
            tlc_pkg::CSR_BLINK_HALF_PERIOD: blink_half_ff       <= csr_wdata;
            tlc_pkg::CSR_DEBOUNCE_TIME:
               debounce_time_ff <= csr_wdata[tlc_pkg::DEBOUNCE_W-1:0];
            default: ;
         endcase
      end
   end

   // Input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_tick_ff  <= req_ch.tick;
         in_level_ff <= req_ch.button_level;
      end
   end

   // Sequencer state, updated once per beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_GREEN;
         phase_elapsed_ff  <= '0;
         blink_elapsed_ff  <= '0;
         blink_on_ff       <= 1'b0;
         debounce_count_ff <= '0;
         previous_raw_ff   <= 1'b1;
         stable_button_ff  <= 1'b1;
      end else if (advance) begin
         phase_ff          <= phase_in;
         phase_elapsed_ff  <= phase_elapsed_in;
         blink_elapsed_ff  <= blink_elapsed_in;
         blink_on_ff       <= blink_on_in;
         debounce_count_ff <= debounce_count_in;
         previous_raw_ff   <= previous_raw_in;
         stable_button_ff  <= stable_button_in;
      end
   end

   // Result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         red_ff       <= red_in;
         yellow_ff    <= yellow_in;
         green_ff     <= green_in;
         rsp_phase_ff <= phase_in;
      end
   end

   // Checks
   `TLC_ASSERT_NEXT(a_timer_change_clears, clock, reset,
      advance && in_tick_ff && !press && phase_in != phase_ff,
      phase_elapsed_ff == '0,
      "timed phase change left elapsed time nonzero")
   `TLC_ASSERT_NEXT(a_press_enters_service, clock, reset,
      advance && press && phase_ff != PH_YELLOW_BLINK,
      phase_ff == PH_YELLOW_BLINK && !blink_on_ff && blink_elapsed_ff == '0,
      "press did not enter service mode cleanly")
   `TLC_ASSERT_IMPLY(a_button_moves_on_beat, clock, reset,
      !$stable(stable_button_ff) && !$past(reset),
      $past(advance),
      "debounced button changed without a beat")
   `TLC_ASSERT_IMPLY(a_no_red_and_green, clock, reset,
      rsp_valid_ff,
      !(red_ff && green_ff),
      "red and green lit together")

endmodule

`default_nettype wire
